### rtl/core/fbfla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfla_pkg
// Shared widths, codes and control structs of the fixed-block allocator.
// ----------------------------------------------------------------------------
package fbfla_pkg;

  localparam int unsigned PoolDepthDef = 256;

  localparam int unsigned OpW      = 2;
  localparam int unsigned IdxPortW = 8;
  localparam int unsigned TotalW   = 9;
  localparam int unsigned SizeW    = 16;
  localparam int unsigned CountW   = 9;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [TotalW-1:0] TotalReset = 9'd256;
  localparam logic [SizeW-1:0]  SizeReset  = 16'd4096;
  localparam logic [CountW-1:0] CountMax   = '1;

  typedef enum logic [OpW-1:0] {
    OP_INIT = 2'd0,
    OP_GET  = 2'd1,
    OP_PUT  = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TOTAL = 1'b0,
    CFG_SIZE  = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_GET  = 2'd1,
    S_INIT = 2'd2
  } state_e;

  typedef struct packed {
    logic    put_push;
    logic    get_read;
    logic    get_pop;
    logic    init_start;
    logic    init_step;
    logic    out_load;
    logic    out_grant;
    status_e out_status;
  } ctl_cmd_t;

  typedef struct packed {
    logic head_valid;
    logic idx_ok;
    logic total_zero;
    logic walk_last;
  } dp_stat_t;

endpackage

### rtl/core/fbfla_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfla_req_if / fbfla_rsp_if
// Valid/ready channels carrying one request word and one response word.
// ----------------------------------------------------------------------------
interface fbfla_req_if;
  import fbfla_pkg::*;

  logic                valid;
  logic                ready;
  logic [OpW-1:0]      operation;
  logic [IdxPortW-1:0] return_index;

  modport source (output valid, output operation, output return_index, input ready);
  modport sink   (input valid, input operation, input return_index, output ready);
endinterface

interface fbfla_rsp_if;
  import fbfla_pkg::*;

  logic                valid;
  logic                ready;
  logic                granted;
  logic [IdxPortW-1:0] granted_index;
  logic [SizeW-1:0]    granted_size;
  logic [CountW-1:0]   free_count;
  logic [StatusW-1:0]  status;

  modport source (output valid, output granted, output granted_index, output granted_size,
                  output free_count, output status, input ready);
  modport sink   (input valid, input granted, input granted_index, input granted_size,
                  input free_count, input status, output ready);
endinterface

### rtl/core/fbfla_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfla_dp
// Link memory, head pointer, free counter, config registers and result word.
// ----------------------------------------------------------------------------
module fbfla_dp #(
  parameter int unsigned POOL_DEPTH = fbfla_pkg::PoolDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fbfla_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fbfla_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic [fbfla_pkg::IdxPortW-1:0] return_index_i,
  input  fbfla_pkg::ctl_cmd_t         cmd_i,
  output fbfla_pkg::dp_stat_t         stat_o,
  output logic                        granted_o,
  output logic [fbfla_pkg::IdxPortW-1:0] granted_index_o,
  output logic [fbfla_pkg::SizeW-1:0]    granted_size_o,
  output logic [fbfla_pkg::CountW-1:0]   free_count_o,
  output logic [fbfla_pkg::StatusW-1:0]  status_o
);
  import fbfla_pkg::*;

  localparam int unsigned IdxW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned LinkW = $clog2(POOL_DEPTH + 1);
  localparam logic [LinkW-1:0] LinkNone = LinkW'(POOL_DEPTH);

  logic [LinkW-1:0] link_mem [POOL_DEPTH];

  logic [TotalW-1:0] total_q;
  logic [SizeW-1:0]  size_q;
  logic [LinkW-1:0]  head_q, head_d;
  logic [CountW-1:0] count_q, count_d;
  logic [LinkW-1:0]  rdata_q;
  logic [IdxW-1:0]   walk_q, walk_last_q;

  logic [LinkW-1:0]  eff_total;
  logic [LinkW-1:0]  init_link;
  logic [IdxW-1:0]   put_addr;
  logic              walk_last;

  logic                granted_q;
  logic [IdxPortW-1:0] granted_index_q;
  logic [SizeW-1:0]    granted_size_q;
  logic [CountW-1:0]   free_count_q;
  status_e             status_q;

  // clamp total to the pool depth
  assign eff_total = (32'(total_q) > 32'(POOL_DEPTH)) ? LinkNone : LinkW'(total_q);
  assign put_addr  = IdxW'(return_index_i);
  assign walk_last = (walk_q == walk_last_q);
  assign init_link = walk_last ? LinkNone : (LinkW'(walk_q) + LinkW'(1));

  assign stat_o.head_valid = (head_q < LinkNone);
  assign stat_o.idx_ok     = (32'(return_index_i) < 32'(eff_total));
  assign stat_o.total_zero = (eff_total == '0);
  assign stat_o.walk_last  = walk_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TotalReset;
      size_q  <= SizeReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_TOTAL: total_q <= TotalW'(cfg_wdata_i);
        CFG_SIZE:  size_q  <= SizeW'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.put_push) begin
      link_mem[put_addr] <= head_q;
    end else if (cmd_i.init_step) begin
      link_mem[walk_q] <= init_link;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.get_read) begin
      rdata_q <= link_mem[head_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_start) begin
      walk_q      <= '0;
      walk_last_q <= IdxW'(eff_total - LinkW'(1));
    end else if (cmd_i.init_step) begin
      walk_q <= walk_q + IdxW'(1);
    end
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.put_push) begin
      head_d = LinkW'(return_index_i);
      if (count_q != CountMax) count_d = count_q + CountW'(1);
    end else if (cmd_i.get_pop) begin
      head_d = (rdata_q < LinkNone) ? rdata_q : LinkNone;
      if (count_q != '0) count_d = count_q - CountW'(1);
    end else if (cmd_i.init_start && stat_o.total_zero) begin
      head_d  = LinkNone;
      count_d = '0;
    end else if (cmd_i.init_step && walk_last) begin
      head_d  = '0;
      count_d = CountW'(eff_total);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= LinkNone;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      granted_q       <= cmd_i.out_grant;
      granted_index_q <= cmd_i.out_grant ? IdxPortW'(head_q) : '0;
      granted_size_q  <= cmd_i.out_grant ? size_q : '0;
      free_count_q    <= count_d;
      status_q        <= cmd_i.out_status;
    end
  end

  assign granted_o       = granted_q;
  assign granted_index_o = granted_index_q;
  assign granted_size_o  = granted_size_q;
  assign free_count_o    = free_count_q;
  assign status_o        = status_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.get_pop |-> (head_q < LinkNone))
    else $error("pop with empty head");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.put_push |=> (head_q == LinkW'($past(return_index_i))))
    else $error("push did not move head");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.init_step |-> (walk_q <= walk_last_q))
    else $error("init walk overran");

endmodule

### rtl/core/fbfla_ctl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfla_ctl
// Sequencer: decodes a request word, runs get and init, owns response valid.
// ----------------------------------------------------------------------------
module fbfla_ctl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fbfla_pkg::op_e       operation_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  fbfla_pkg::dp_stat_t  stat_i,
  output fbfla_pkg::ctl_cmd_t  cmd_o
);
  import fbfla_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    accept     = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = !out_valid_q || out_ready_i;
        accept     = in_valid_i && in_ready_o;
        if (accept) begin
          case (operation_i)
            OP_INIT: begin
              cmd_o.init_start = 1'b1;
              if (stat_i.total_zero) begin
                cmd_o.out_load = 1'b1;
              end else begin
                state_d = S_INIT;
              end
            end
            OP_GET: begin
              if (stat_i.head_valid) begin
                cmd_o.get_read = 1'b1;
                state_d        = S_GET;
              end else begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = ST_EMPTY;
              end
            end
            OP_PUT: begin
              cmd_o.out_load = 1'b1;
              if (stat_i.idx_ok) begin
                cmd_o.put_push = 1'b1;
              end else begin
                cmd_o.out_status = ST_RANGE;
              end
            end
            default: cmd_o.out_load = 1'b1;
          endcase
        end
      end
      S_GET: begin
        cmd_o.get_pop   = 1'b1;
        cmd_o.out_load  = 1'b1;
        cmd_o.out_grant = 1'b1;
        state_d         = S_IDLE;
      end
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (stat_i.walk_last) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("response word overwritten");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("request taken while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.get_read |=> (state_q == S_GET))
    else $error("get read without pop");

endmodule

### rtl/core/fixed_block_free_list_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Pool of equal-size buffers handed out and taken back through a LIFO list.
// ----------------------------------------------------------------------------
// One request word at a time. Put, an out-of-range put, a get on an empty
// pool, an init with a zero total and the no-op code finish at the accept
// edge, where the response word is registered. A get first reads the head's
// link from the link memory, then moves the head. Init writes one link per
// cycle, stepping through the clamped buffer total. A new request is taken
// while the previous response word sits in its register as long as that
// word is being taken in the same cycle.
module fixed_block_free_list_allocator #(
  parameter int unsigned POOL_DEPTH = fbfla_pkg::PoolDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fbfla_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fbfla_pkg::CfgDataW-1:0] cfg_wdata_i,
  fbfla_req_if.sink                      req_i,
  fbfla_rsp_if.source                    rsp_o
);
  import fbfla_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  fbfla_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .operation_i (op_e'(req_i.operation)),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fbfla_dp #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .return_index_i  (req_i.return_index),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .granted_o       (rsp_o.granted),
    .granted_index_o (rsp_o.granted_index),
    .granted_size_o  (rsp_o.granted_size),
    .free_count_o    (rsp_o.free_count),
    .status_o        (rsp_o.status)
  );

endmodule

### tb/fbfla_free_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbfla_free_list_checker
// Watches the config port and both channels of the allocator, keeps its own
// copy of the free list, and checks every response word against it.
// ----------------------------------------------------------------------------
module fbfla_free_list_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fbfla_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fbfla_pkg::CfgDataW-1:0] cfg_wdata_i,
  fbfla_req_if                           req_mon,
  fbfla_rsp_if                           rsp_mon,
  output int unsigned                    outstanding_o,
  output int unsigned                    error_count_o
);
  import fbfla_pkg::*;

  localparam int unsigned      PoolDepth = PoolDepthDef;
  localparam logic [TotalW-1:0] LinkNone = TotalW'(PoolDepth);

  typedef struct packed {
    logic                granted;
    logic [IdxPortW-1:0] index;
    logic [SizeW-1:0]    size;
    logic [CountW-1:0]   count;
    status_e             status;
  } grant_word_t;

  logic [TotalW-1:0] link_mem [PoolDepth];
  logic [TotalW-1:0] head_ptr;
  logic [CountW-1:0] free_cnt;
  logic [TotalW-1:0] total_cfg;
  logic [SizeW-1:0]  size_cfg;
  grant_word_t       grant_words_q[$];

  function automatic int unsigned clamped_total();
    return (total_cfg > PoolDepth) ? PoolDepth : int'(total_cfg);
  endfunction

  task automatic predict(input logic [OpW-1:0] op, input logic [IdxPortW-1:0] idx);
    grant_word_t       w;
    int unsigned       t;
    logic [TotalW-1:0] nxt;
    w = '0;
    w.status = ST_OK;
    t = clamped_total();
    case (op)
      OP_INIT: begin
        for (int unsigned i = 0; i < t; i++) begin
          link_mem[i] = (i + 1 < t) ? TotalW'(i + 1) : LinkNone;
        end
        head_ptr = (t > 0) ? '0 : LinkNone;
        free_cnt = CountW'(t);
      end
      OP_GET: begin
        if (head_ptr < PoolDepth) begin
          nxt       = link_mem[head_ptr[IdxPortW-1:0]];
          w.granted = 1'b1;
          w.index   = head_ptr[IdxPortW-1:0];
          w.size    = size_cfg;
          head_ptr  = (nxt < PoolDepth) ? nxt : LinkNone;
          if (free_cnt != '0) free_cnt--;
        end else begin
          w.status = ST_EMPTY;
        end
      end
      OP_PUT: begin
        if (idx < t) begin
          link_mem[idx] = head_ptr;
          head_ptr      = TotalW'(idx);
          if (free_cnt != CountMax) free_cnt++;
        end else begin
          w.status = ST_RANGE;
        end
      end
      default: ;
    endcase
    w.count = free_cnt;
    grant_words_q.push_back(w);
  endtask

  task automatic check_word(input grant_word_t w);
    if (rsp_mon.granted !== w.granted) begin
      $error("granted: expected %0d, actual %0d", w.granted, rsp_mon.granted);
      error_count_o++;
    end
    if (rsp_mon.granted_index !== w.index) begin
      $error("granted_index: expected %0d, actual %0d", w.index, rsp_mon.granted_index);
      error_count_o++;
    end
    if (rsp_mon.granted_size !== w.size) begin
      $error("granted_size: expected %0d, actual %0d", w.size, rsp_mon.granted_size);
      error_count_o++;
    end
    if (rsp_mon.free_count !== w.count) begin
      $error("free_count: expected %0d, actual %0d", w.count, rsp_mon.free_count);
      error_count_o++;
    end
    if (rsp_mon.status !== w.status) begin
      $error("status: expected %0d, actual %0d", w.status, rsp_mon.status);
      error_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_ptr  = LinkNone;
      free_cnt  = '0;
      total_cfg = TotalReset;
      size_cfg  = SizeReset;
      grant_words_q.delete();
      outstanding_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_TOTAL) total_cfg = cfg_wdata_i[TotalW-1:0];
        else size_cfg = cfg_wdata_i[SizeW-1:0];
      end
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (grant_words_q.size() == 0) begin
          $error("response word with nothing expected");
          error_count_o++;
        end else begin
          check_word(grant_words_q.pop_front());
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        predict(req_mon.operation, req_mon.return_index);
      end
      outstanding_o = grant_words_q.size();
    end
  end

endmodule

### tb/fixed_block_free_list_allocator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_test
// Drives init/get/put words through the allocator under several pool sizes,
// with bursty requests and a stalling receiver; a checker module beside the
// block predicts and compares each response word.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_test;
  import fbfla_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumPhases  = 9;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  int unsigned         outstanding;
  int unsigned         error_count;
  int unsigned         cycle_count;
  int unsigned         burst_left;
  int unsigned         total_now;
  bit                  squeeze_req;
  bit                  squeeze_done;

  fbfla_req_if req_bus ();
  fbfla_rsp_if rsp_bus ();

  fixed_block_free_list_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  fbfla_free_list_checker checker_u (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_mon       (req_bus),
    .rsp_mon       (rsp_bus),
    .outstanding_o (outstanding),
    .error_count_o (error_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // bursts of random length; some bursts follow with no gap at all
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        @(negedge clk_i);
        req_bus.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic send_word(input op_e op, input logic [IdxPortW-1:0] idx);
    pace();
    @(negedge clk_i);
    req_bus.valid        <= 1'b1;
    req_bus.operation    <= op;
    req_bus.return_index <= idx;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
  endtask

  task automatic settle();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    total_now = (idx != CFG_TOTAL) ? total_now :
                (data[TotalW-1:0] > PoolDepthDef) ? PoolDepthDef : int'(data[TotalW-1:0]);
  endtask

  // receiver: stall pattern of its own, plus one long hold-off on request
  initial begin
    int unsigned mode;
    int unsigned len;
    rsp_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(20, 150);
      for (int unsigned k = 0; k < len; k++) begin
        @(negedge clk_i);
        if (squeeze_req && !squeeze_done) begin
          rsp_bus.ready <= 1'b0;
          repeat (300) @(negedge clk_i);
          squeeze_done = 1'b1;
        end
        case (mode)
          0:       rsp_bus.ready <= 1'b1;
          1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
          2:       rsp_bus.ready <= 1'($urandom_range(0, 1));
          default: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned phase_total [NumPhases];
    int unsigned phase_size  [NumPhases];
    int unsigned r;
    op_e         op;
    logic [IdxPortW-1:0] idx;

    phase_total = '{1, 2, 17, 256, 300, 0, 64, 511, 5};
    phase_size  = '{65535, 1, 1234, 0, 0, 7, 0, 4096, 65535};
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_index_i          = CFG_TOTAL;
    cfg_wdata_i          = '0;
    req_bus.valid        = 1'b0;
    req_bus.operation    = OP_NOP;
    req_bus.return_index = '0;
    total_now            = PoolDepthDef;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // before any init, list is empty
    send_word(OP_GET, 8'd0);
    send_word(OP_NOP, 8'hFF);
    send_word(OP_PUT, 8'd0);
    send_word(OP_GET, 8'd0);
    send_word(OP_GET, 8'd0);
    send_word(OP_PUT, 8'd255);

    // small pool: exhaust, out-of-range put, double free, count floor
    settle();
    write_reg(CFG_TOTAL, 16'd3);
    write_reg(CFG_SIZE, 16'hFFFF);
    send_word(OP_INIT, 8'd0);
    repeat (4) send_word(OP_GET, 8'd0);
    send_word(OP_PUT, 8'd3);
    send_word(OP_PUT, 8'd2);
    send_word(OP_PUT, 8'd2);
    repeat (3) send_word(OP_GET, 8'd0);

    // zero total
    settle();
    write_reg(CFG_TOTAL, 16'd0);
    send_word(OP_INIT, 8'd0);
    send_word(OP_GET, 8'd0);
    send_word(OP_PUT, 8'd0);

    // total above pool depth is clamped
    settle();
    write_reg(CFG_TOTAL, 16'd511);
    write_reg(CFG_SIZE, 16'd0);
    send_word(OP_INIT, 8'd0);
    send_word(OP_GET, 8'd0);
    send_word(OP_PUT, 8'd255);
    send_word(OP_GET, 8'd0);

    // full pool, then enough puts to pin the count at its ceiling
    settle();
    write_reg(CFG_TOTAL, 16'd256);
    write_reg(CFG_SIZE, 16'd4096);
    squeeze_req = 1'b1;
    send_word(OP_INIT, 8'd0);
    repeat (280) send_word(OP_PUT, IdxPortW'($urandom_range(0, 255)));
    repeat (60) send_word(OP_GET, 8'd0);

    // odd phases keep the old list so a new total only bounds puts
    for (int unsigned p = 0; p < NumPhases; p++) begin
      settle();
      write_reg(CFG_TOTAL, CfgDataW'(phase_total[p]));
      write_reg(CFG_SIZE, CfgDataW'((p == 3 || p == 6) ? $urandom_range(0, 65535) :
                                                         phase_size[p]));
      if (p % 2 == 0) send_word(OP_INIT, IdxPortW'($urandom_range(0, 255)));
      repeat (30) begin
        r = $urandom_range(0, 99);
        if (r < 3) op = OP_INIT;
        else if (r < 45) op = OP_GET;
        else if (r < 92) op = OP_PUT;
        else op = OP_NOP;
        if (op == OP_PUT && total_now > 0 && $urandom_range(0, 3) != 0) begin
          idx = IdxPortW'($urandom_range(0, total_now - 1));
        end else begin
          idx = IdxPortW'($urandom_range(0, 255));
        end
        send_word(op, idx);
      end
    end

    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
